FILE: rtl/core/tbs_pkg.sv
// Shared types and constants for the token bucket shaper.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps

package tbs_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 16;

	localparam int unsigned TOK_W  = 16;
	localparam int unsigned ID_W   = 16;
	localparam int unsigned EV_W   = 3;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_DEPTH   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_TOKENS = 1'b1;

	localparam logic [TOK_W-1:0] BUCKET_DEPTH_RST   = 16'd10;
	localparam logic [TOK_W-1:0] INITIAL_TOKENS_RST = 16'd3;

	// request commands
	localparam logic CMD_ARRIVAL = 1'b0;
	localparam logic CMD_TICK    = 1'b1;

	// result event codes
	localparam logic [EV_W-1:0] EV_ENQ      = 3'd0;
	localparam logic [EV_W-1:0] EV_BIG      = 3'd1;
	localparam logic [EV_W-1:0] EV_FULL     = 3'd2;
	localparam logic [EV_W-1:0] EV_TOK_ADD  = 3'd3;
	localparam logic [EV_W-1:0] EV_TOK_DROP = 3'd4;
	localparam logic [EV_W-1:0] EV_REL      = 3'd5;

	// one queue entry: token need and packet id
	typedef struct packed {
		logic [TOK_W-1:0] need;
		logic [ID_W-1:0]  id;
	} tbs_entry_t;

	// controller -> datapath
	typedef struct packed {
		logic take_in;   // request accepted this cycle
		logic emit_pend; // move the pending result to the output register
		logic rel_head;  // head packet leaves together with the emit
	} tbs_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;  // output register can take a result this cycle
		logic head_ok;   // queue not empty and head need covered by tokens
	} tbs_stat_t;

endpackage

FILE: rtl/core/tbs_if.sv
// Handshake channels of the token bucket shaper: request in, result out.
// Depends on tbs_pkg for field widths.
`timescale 1ns / 1ps

interface tbs_req_if;
	logic                       valid;
	logic                       ready;
	logic                       cmd;
	logic [tbs_pkg::TOK_W-1:0] tokens_needed;

	modport source (output valid, output cmd, output tokens_needed, input ready);
	modport sink   (input valid, input cmd, input tokens_needed, output ready);
endinterface

interface tbs_res_if #(
	parameter int unsigned CNT_W = 5
);
	logic                       valid;
	logic                       ready;
	logic [tbs_pkg::EV_W-1:0]  event_res;
	logic [tbs_pkg::ID_W-1:0]  packet_id;
	logic [tbs_pkg::TOK_W-1:0] tokens_now;
	logic [CNT_W-1:0]           queue_count;
	logic                       last;

	modport source (output valid, output event_res, output packet_id, output tokens_now,
		output queue_count, output last, input ready);
	modport sink   (input valid, input event_res, input packet_id, input tokens_now,
		input queue_count, input last, output ready);
endinterface

FILE: rtl/core/tbs_ctrl.sv
// Sequencer of the token bucket shaper: request acceptance and release loop.
// Depends on tbs_pkg for the command and status structs.
`timescale 1ns / 1ps

module tbs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_cmd,
	output logic                req_ready,
	input  tbs_pkg::tbs_stat_t stat,
	output tbs_pkg::tbs_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_READ  = 3'b010,
		S_CHECK = 3'b100
	} state_t;

	state_t state_q, state_d;

	assign req_ready = (state_q == S_IDLE) && stat.out_free;

	always_comb begin
		state_d       = state_q;
		cmd.take_in   = 1'b0;
		cmd.emit_pend = 1'b0;
		cmd.rel_head  = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd.take_in = req_valid && req_ready;
				if (cmd.take_in && (req_cmd == tbs_pkg::CMD_TICK)) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				// head entry read is in flight
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (stat.out_free) begin
					cmd.emit_pend = 1'b1;
					cmd.rel_head  = stat.head_ok;
					state_d       = stat.head_ok ? S_READ : S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("controller state not one-hot");
	a_read_check: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |=> state_q == S_CHECK)
		else $error("head read not followed by check");
	a_rel_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rel_head |-> cmd.emit_pend && state_q == S_CHECK)
		else $error("release outside of an emit");

endmodule

FILE: rtl/core/tbs_dp.sv
// Datapath of the token bucket shaper: registers, bucket, wait queue memory,
// pending result and output register. Depends on tbs_pkg and tbs_if.
`timescale 1ns / 1ps

module tbs_dp #(
	parameter int unsigned QUEUE_DEPTH = tbs_pkg::QUEUE_DEPTH_DEF,
	parameter int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tbs_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [tbs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                             req_cmd,
	input  logic [tbs_pkg::TOK_W-1:0]       req_need,
	input  tbs_pkg::tbs_cmd_t               cmd,
	output tbs_pkg::tbs_stat_t              stat,
	tbs_res_if.source                        res
);

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	logic [tbs_pkg::TOK_W-1:0] depth_q, init_q, level_q;
	logic [tbs_pkg::ID_W-1:0]  arr_cnt_q;
	logic [PTR_W-1:0]          head_q, tail_q;
	logic [CNT_W-1:0]          fill_q;

	tbs_pkg::tbs_entry_t mem [QUEUE_DEPTH];
	tbs_pkg::tbs_entry_t rd_q;

	// pending result, held until its last flag is known
	logic [tbs_pkg::EV_W-1:0]  pend_ev_q;
	logic [tbs_pkg::ID_W-1:0]  pend_id_q;
	logic [tbs_pkg::TOK_W-1:0] pend_tok_q;
	logic [CNT_W-1:0]          pend_cnt_q;

	logic                      out_valid_q;
	logic [tbs_pkg::EV_W-1:0]  out_ev_q;
	logic [tbs_pkg::ID_W-1:0]  out_id_q;
	logic [tbs_pkg::TOK_W-1:0] out_tok_q;
	logic [CNT_W-1:0]          out_cnt_q;
	logic                      out_last_q;

	logic                      take_arr, take_tick, too_big, q_full, do_enq, tok_full;
	logic [tbs_pkg::ID_W-1:0]  id_next;
	logic [tbs_pkg::EV_W-1:0]  arr_ev;
	logic [tbs_pkg::TOK_W-1:0] level_rel;
	logic [tbs_pkg::TOK_W-1:0] level_tick;

	assign take_arr  = cmd.take_in && (req_cmd == tbs_pkg::CMD_ARRIVAL);
	assign take_tick = cmd.take_in && (req_cmd == tbs_pkg::CMD_TICK);
	assign id_next   = arr_cnt_q + 16'd1;
	assign too_big   = req_need > depth_q;
	assign q_full    = fill_q == CNT_FULL;
	assign do_enq    = take_arr && !too_big && !q_full;
	assign arr_ev    = too_big ? tbs_pkg::EV_BIG : (q_full ? tbs_pkg::EV_FULL : tbs_pkg::EV_ENQ);
	assign tok_full  = level_q >= depth_q;
	assign level_tick = tok_full ? level_q : level_q + 16'd1;
	assign level_rel = level_q - rd_q.need;

	assign stat.out_free = !out_valid_q || res.ready;
	assign stat.head_ok  = (fill_q != '0) && (rd_q.need <= level_q);

	// wait queue memory
	always_ff @(posedge clk) begin
		if (do_enq) begin
			mem[tail_q] <= '{need: req_need, id: id_next};
		end
		rd_q <= mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q   <= tbs_pkg::BUCKET_DEPTH_RST;
			init_q    <= tbs_pkg::INITIAL_TOKENS_RST;
			level_q   <= tbs_pkg::INITIAL_TOKENS_RST;
			arr_cnt_q <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			fill_q    <= '0;
		end else begin
			if (cfg_we && cfg_idx == tbs_pkg::CFG_BUCKET_DEPTH) begin
				depth_q <= cfg_wdata;
			end
			if (cfg_we && cfg_idx == tbs_pkg::CFG_INITIAL_TOKENS) begin
				init_q  <= cfg_wdata;
				level_q <= cfg_wdata;
			end else if (take_tick) begin
				level_q <= level_tick;
			end else if (cmd.rel_head) begin
				level_q <= level_rel;
			end
			if (take_arr) begin
				arr_cnt_q <= id_next;
			end
			if (do_enq) begin
				tail_q <= (tail_q == PTR_LAST) ? '0 : tail_q + PTR_W'(1);
				fill_q <= fill_q + CNT_W'(1);
			end else if (cmd.rel_head) begin
				head_q <= (head_q == PTR_LAST) ? '0 : head_q + PTR_W'(1);
				fill_q <= fill_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_tick) begin
			pend_ev_q  <= tok_full ? tbs_pkg::EV_TOK_DROP : tbs_pkg::EV_TOK_ADD;
			pend_id_q  <= '0;
			pend_tok_q <= level_tick;
			pend_cnt_q <= fill_q;
		end else if (cmd.rel_head) begin
			pend_ev_q  <= tbs_pkg::EV_REL;
			pend_id_q  <= rd_q.id;
			pend_tok_q <= level_rel;
			pend_cnt_q <= fill_q - CNT_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take_arr || cmd.emit_pend) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_arr) begin
			out_ev_q   <= arr_ev;
			out_id_q   <= id_next;
			out_tok_q  <= level_q;
			out_cnt_q  <= do_enq ? fill_q + CNT_W'(1) : fill_q;
			out_last_q <= 1'b1;
		end else if (cmd.emit_pend) begin
			out_ev_q   <= pend_ev_q;
			out_id_q   <= pend_id_q;
			out_tok_q  <= pend_tok_q;
			out_cnt_q  <= pend_cnt_q;
			out_last_q <= !cmd.rel_head;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.event_res   = out_ev_q;
	assign res.packet_id   = out_id_q;
	assign res.tokens_now  = out_tok_q;
	assign res.queue_count = out_cnt_q;
	assign res.last        = out_last_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n) fill_q <= CNT_FULL)
		else $error("queue fill above depth");
	a_rel_covered: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rel_head |-> fill_q != '0 && rd_q.need <= level_q)
		else $error("release without covering tokens");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(take_arr || cmd.emit_pend) |-> (!out_valid_q || res.ready))
		else $error("output register overwritten while held");

endmodule

FILE: rtl/core/token_bucket_shaper_core.sv
// Token bucket shaper top level: joins controller, datapath and channels.
// An arrival is answered from idle; a tick runs READ then CHECK per release, plus a final pair.
// Each release costs a registered head read of the queue memory plus a check.
// Reset: asynchronous, active low; bucket depth 10, initial and current
// tokens 3, queue empty, arrival counter zero. Queue memory is not cleared.
`timescale 1ns / 1ps

module token_bucket_shaper_core #(
	parameter int unsigned QUEUE_DEPTH = tbs_pkg::QUEUE_DEPTH_DEF,
	parameter int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tbs_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [tbs_pkg::CFG_DATA_W-1:0] cfg_wdata,
	tbs_req_if.sink                         req,
	tbs_res_if.source                       res
);

	// Controller and datapath talk only through these two structs.
	tbs_pkg::tbs_cmd_t  cmd;
	tbs_pkg::tbs_stat_t stat;
	logic               req_ready;

	// A request is taken only while the sequencer is idle and the output
	// register is free or being drained in the same cycle.
	assign req.ready = req_ready;

	tbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_cmd   (req.cmd),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Datapath holds bucket state, the wait queue memory (one write port at
	// the tail, one registered read port at the head) and the result register.
	tbs_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.CNT_W       (CNT_W)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.req_cmd   (req.cmd),
		.req_need  (req.tokens_needed),
		.cmd       (cmd),
		.stat      (stat),
		.res       (res)
	);

endmodule
